FILE: rtl/ssfs_pkg.sv
`default_nettype none

package ssfs_pkg;

  // Number of selectable sources and the width of a memory index.
  localparam int NumSources = 10;
  localparam int IdxW       = (NumSources > 1) ? $clog2(NumSources) : 1;

  // Fixed field widths.
  localparam int SrcW  = 4;
  localparam int ChanW = 8;
  localparam int HoldW = 8;
  localparam int TimeW = 32;

  localparam logic [IdxW-1:0]  LastIdx       = IdxW'(NumSources - 1);
  localparam logic [ChanW-1:0] IgnoreChannel = 8'd100;
  localparam logic [HoldW-1:0] HoldoffReset  = 8'd2;

  typedef enum logic [1:0] {
    KIND_TICK    = 2'd0,
    KIND_PACKET  = 2'd1,
    KIND_CHANNEL = 2'd2,
    KIND_POLL    = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CUR,
    ST_ZERO,
    ST_SCAN
  } state_e;

  // Access to the last-seen memory: one write and one read port.
  typedef struct packed {
    logic             we;
    logic [IdxW-1:0]  waddr;
    logic [TimeW-1:0] wdata;
    logic             re;
    logic [IdxW-1:0]  raddr;
  } mem_req_t;

endpackage

`default_nettype wire

FILE: rtl/stream_source_failover_selector.sv
`default_nettype none

// Channel     Ports                                   Direction  Handshake
// request     start, kind_i, port_i, channel_i        in         start && !busy
// result      done_o, source_o, switched_o, refused_o out        done_o, one cycle
// config      holdoff_we_i, holdoff_i                 in         holdoff_we_i
//
// Ticks, packet stamps and channel requests are handled on acceptance; the result strobe
// follows in the next cycle and busy stays low, so a new request may enter
// right away. A poll that may switch reads the last-seen memory once for the
// current source and then, when that source is stale, once per source in turn,
// else once for source 0; busy stays high until it is done, as the reads go
// one at a time through the single read port of the memory. Reset is asynchronous
// and active low and clears all time state at once through per-entry valid bits.
// The receiver cannot stall: every result is shown for exactly one cycle.
module stream_source_failover_selector (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        start,
  output logic                             busy,
  input  wire logic [1:0]                  kind_i,
  input  wire logic [ssfs_pkg::SrcW-1:0]   port_i,
  input  wire logic [ssfs_pkg::ChanW-1:0]  channel_i,
  output logic                             done_o,
  output logic [ssfs_pkg::SrcW-1:0]        source_o,
  output logic                             switched_o,
  output logic                             refused_o,
  input  wire logic                        holdoff_we_i,
  input  wire logic [ssfs_pkg::HoldW-1:0]  holdoff_i
);

  ssfs_pkg::state_e                 state_q, state_d;
  logic [ssfs_pkg::TimeW-1:0]       seconds_q, seconds_d;
  logic [ssfs_pkg::TimeW-1:0]       change_q, change_d;
  logic [ssfs_pkg::SrcW-1:0]        cur_q, cur_d;
  logic [ssfs_pkg::SrcW-1:0]        before_q, before_d;
  logic [ssfs_pkg::HoldW-1:0]       holdoff_q;
  logic [ssfs_pkg::IdxW-1:0]        idx_q, idx_d;
  logic [ssfs_pkg::TimeW-1:0]       best_q, best_d;

  logic                             done_q, done_d;
  logic [ssfs_pkg::SrcW-1:0]        res_src_q, res_src_d;
  logic                             res_sw_q, res_sw_d;
  logic                             res_ref_q, res_ref_d;

  ssfs_pkg::mem_req_t               mem_req;
  logic [ssfs_pkg::TimeW-1:0]       mem_rdata;

  ssfs_pkg::kind_e                  kind;
  logic                             accept;
  logic [ssfs_pkg::TimeW-1:0]       hold_ext;
  logic                             can_change;
  logic [ssfs_pkg::TimeW-1:0]       rd_age;
  logic                             rd_stale;
  logic                             rd_better;
  logic                             zero_fresh;
  logic                             chan_ok;
  logic                             port_ok;
  logic [ssfs_pkg::SrcW-1:0]        before_sel;

  ssfs_seen_mem u_seen_mem (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (mem_req),
    .rdata_o (mem_rdata)
  );

  assign kind   = ssfs_pkg::kind_e'(kind_i);
  assign accept = start && (state_q == ssfs_pkg::ST_IDLE);
  assign busy   = (state_q != ssfs_pkg::ST_IDLE);

  // Ages are modular differences against the running second counter.
  assign hold_ext   = {{(ssfs_pkg::TimeW - ssfs_pkg::HoldW){1'b0}}, holdoff_q};
  assign can_change = (seconds_q - change_q) > hold_ext;
  assign rd_age     = seconds_q - mem_rdata;
  assign rd_stale   = rd_age > hold_ext;
  assign rd_better  = rd_age < best_q;
  assign zero_fresh = (rd_age == '0);

  // The ignore code only matters when the source count reaches past it.
  assign chan_ok = (channel_i != ssfs_pkg::IgnoreChannel) &&
                   (channel_i < ssfs_pkg::ChanW'(ssfs_pkg::NumSources));
  assign port_ok = ({1'b0, port_i} < (ssfs_pkg::SrcW + 1)'(ssfs_pkg::NumSources));

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ssfs_pkg::ST_IDLE: begin
        if (accept && (kind == ssfs_pkg::KIND_POLL) && can_change) begin
          state_d = ssfs_pkg::ST_CUR;
        end
      end
      ssfs_pkg::ST_CUR: begin
        state_d = rd_stale ? ssfs_pkg::ST_SCAN : ssfs_pkg::ST_ZERO;
      end
      ssfs_pkg::ST_ZERO: begin
        state_d = ssfs_pkg::ST_IDLE;
      end
      ssfs_pkg::ST_SCAN: begin
        if (idx_q == ssfs_pkg::LastIdx) begin
          state_d = ssfs_pkg::ST_IDLE;
        end
      end
      default: state_d = ssfs_pkg::ST_IDLE;
    endcase
  end

  // Datapath and result.
  always_comb begin
    seconds_d = seconds_q;
    change_d  = change_q;
    cur_d     = cur_q;
    before_d  = before_q;
    idx_d     = idx_q;
    best_d    = best_q;
    done_d    = 1'b0;
    res_ref_d = 1'b0;
    mem_req   = '0;

    unique case (state_q)
      ssfs_pkg::ST_IDLE: begin
        if (accept) begin
          before_d = cur_q;
          case (kind)
            ssfs_pkg::KIND_TICK: begin
              seconds_d = seconds_q + 1'b1;
              done_d    = 1'b1;
            end
            ssfs_pkg::KIND_PACKET: begin
              mem_req.we    = port_ok;
              mem_req.waddr = port_i[ssfs_pkg::IdxW-1:0];
              mem_req.wdata = seconds_q;
              done_d        = 1'b1;
            end
            ssfs_pkg::KIND_CHANNEL: begin
              if (!can_change) begin
                res_ref_d = 1'b1;
              end else if (chan_ok) begin
                cur_d    = channel_i[ssfs_pkg::SrcW-1:0];
                change_d = seconds_q;
              end
              done_d = 1'b1;
            end
            default: begin
              // Poll: fetch the current source's stamp, or finish at once
              // when the hold-off still runs.
              if (can_change) begin
                mem_req.re    = 1'b1;
                mem_req.raddr = cur_q[ssfs_pkg::IdxW-1:0];
              end else begin
                done_d = 1'b1;
              end
            end
          endcase
        end
      end
      ssfs_pkg::ST_CUR: begin
        mem_req.re    = 1'b1;
        mem_req.raddr = '0;
        best_d        = rd_age;
        idx_d         = '0;
      end
      ssfs_pkg::ST_ZERO: begin
        if (zero_fresh) begin
          cur_d    = '0;
          change_d = seconds_q;
        end
        done_d = 1'b1;
      end
      ssfs_pkg::ST_SCAN: begin
        if (rd_better) begin
          cur_d    = ssfs_pkg::SrcW'(idx_q);
          best_d   = rd_age;
          change_d = seconds_q;
        end
        if (idx_q == ssfs_pkg::LastIdx) begin
          done_d = 1'b1;
        end else begin
          idx_d         = idx_q + 1'b1;
          mem_req.re    = 1'b1;
          mem_req.raddr = idx_q + 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  assign before_sel = (state_q == ssfs_pkg::ST_IDLE) ? cur_q : before_q;
  assign res_src_d  = done_d ? cur_d : res_src_q;
  assign res_sw_d   = done_d ? (cur_d != before_sel) : res_sw_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ssfs_pkg::ST_IDLE;
      seconds_q <= '0;
      change_q  <= '0;
      cur_q     <= '0;
      holdoff_q <= ssfs_pkg::HoldoffReset;
      done_q    <= 1'b0;
    end else begin
      state_q   <= state_d;
      seconds_q <= seconds_d;
      change_q  <= change_d;
      cur_q     <= cur_d;
      done_q    <= done_d;
      if (holdoff_we_i) begin
        holdoff_q <= holdoff_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    before_q  <= before_d;
    idx_q     <= idx_d;
    best_q    <= best_d;
    res_src_q <= res_src_d;
    res_sw_q  <= res_sw_d;
    res_ref_q <= done_d ? res_ref_d : res_ref_q;
  end

  assign done_o     = done_q;
  assign source_o   = res_src_q;
  assign switched_o = res_sw_q;
  assign refused_o  = res_ref_q;

endmodule

`default_nettype wire

FILE: rtl/ssfs_seen_mem.sv
`default_nettype none

// Last-seen time per source. Entries that were never written read as zero.
module ssfs_seen_mem (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire ssfs_pkg::mem_req_t         req_i,
  output logic [ssfs_pkg::TimeW-1:0]      rdata_o
);

  logic [ssfs_pkg::TimeW-1:0]      mem_q [ssfs_pkg::NumSources];
  logic [ssfs_pkg::NumSources-1:0] vld_q;
  logic [ssfs_pkg::TimeW-1:0]      rdata_q;
  logic                            rvld_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem_q[req_i.waddr] <= req_i.wdata;
    end
    if (req_i.re) begin
      rdata_q <= mem_q[req_i.raddr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q  <= '0;
      rvld_q <= 1'b0;
    end else begin
      if (req_i.we) begin
        vld_q[req_i.waddr] <= 1'b1;
      end
      if (req_i.re) begin
        rvld_q <= vld_q[req_i.raddr];
      end
    end
  end

  assign rdata_o = rvld_q ? rdata_q : '0;

endmodule

`default_nettype wire
